@@ design/tkst_pkg.sv @@
`default_nettype none

package tkst_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 16;
    localparam int NAME_CHARS  = 8;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int COUNT_W     = 5;
    localparam int READ_IDX_W  = 4;

    // Field widths
    localparam int IN_SCORE_W  = 32;
    localparam int SCORE_W     = 31;
    localparam int NAME_W      = 64;
    localparam int RANK_W      = 4;

    // Stream packing
    localparam int IN_DATA_W   = IN_SCORE_W + NAME_W + READ_IDX_W;
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 1 + RANK_W + 1 + SCORE_W + NAME_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    // Packed text used for an empty name, first char in the low byte
    localparam logic [NAME_W-1:0] DEFAULT_NAME = 64'h0000_7265_7961_6C50;

    // Mode codes carried on s_tuser
    localparam logic MODE_SUBMIT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // Item travelling down the cell chain
    typedef struct packed {
        logic                 valid;
        logic                 is_new;
        logic [SCORE_W-1:0]   score;
        logic [NAME_W-1:0]    name;
    } carry_t;

endpackage

`default_nettype wire

@@ design/top_k_sorted_insert_table.sv @@
// Channel  | Ports                     | Fields (low bit first)
// s_ input | s_tvalid/s_tready/s_tdata | tdata: new_score, name_tag, read_index
//          | s_tuser                   | tuser: mode (0 submit, 1 read)
// m_ result| m_tvalid/m_tready/m_tdata | tdata: accepted, final_rank, entry_valid,
//          |                           |        entry_score, entry_name, entry_count
//
// A submit travels down a chain of MAX_ENTRIES cells, one cell per cycle, before its
// result is staged; a read captures the addressed cell when it is accepted.
// One item is worked at a time; the next is accepted while a result waits on m_.
// Reset (aresetn low, synchronous) empties the table; stored entries are not cleared.
// A stall on m_tready holds the result and blocks only the item after the next.
`default_nettype none

module top_k_sorted_insert_table
    import tkst_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // new_score, name_tag, read_index
    input  wire logic                   s_tuser,   // mode
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // accepted, final_rank, entry_valid,
                                                   // entry_score, entry_name, entry_count
);

    typedef enum logic [1:0] {ST_IDLE, ST_WAVE, ST_DONE} state_t;

    state_t               state_reg;
    logic                 m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    carry_t               inject_reg;
    logic [COUNT_W-1:0]   held_count_reg;
    logic [IDX_W-1:0]     wave_cnt_reg;
    logic                 acc_reg;
    logic [RANK_W-1:0]    rank_reg;

    logic                 pend_acc_reg;
    logic [RANK_W-1:0]    pend_rank_reg;
    logic                 pend_ev_reg;
    logic [SCORE_W-1:0]   pend_score_reg;
    logic [NAME_W-1:0]    pend_name_reg;
    logic [COUNT_W-1:0]   pend_count_reg;

    carry_t               chain [0:MAX_ENTRIES];
    logic [SCORE_W-1:0]   cell_score [0:MAX_ENTRIES-1];
    logic [NAME_W-1:0]    cell_name  [0:MAX_ENTRIES-1];
    logic [MAX_ENTRIES-1:0] took_vec;

    logic                 s_fire;
    logic                 slot_free;
    logic                 in_mode;
    logic [IN_SCORE_W-1:0] in_score;
    logic [NAME_W-1:0]    in_name;
    logic [READ_IDX_W-1:0] in_idx;
    logic [SCORE_W-1:0]   clamp_score;
    logic [NAME_W-1:0]    norm_name;
    logic                 any_took;
    logic [RANK_W-1:0]    took_rank;
    logic                 rd_valid;
    logic [IDX_W-1:0]     rd_addr;

    // Keep only bytes up to the first zero; an empty name becomes the default
    function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_W-1:0] tag);
        logic [NAME_W-1:0] res;
        logic              live;
        res  = '0;
        live = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b < NAME_CHARS) begin
                if (tag[8*b +: 8] == 8'd0) begin
                    live = 1'b0;
                end
                if (live) begin
                    res[8*b +: 8] = tag[8*b +: 8];
                end
            end
        end
        if (res == '0) begin
            for (int b = 0; b < 8; b++) begin
                if (b < NAME_CHARS) begin
                    res[8*b +: 8] = DEFAULT_NAME[8*b +: 8];
                end
            end
        end
        return res;
    endfunction

    // Unpack the input item
    assign in_mode  = s_tuser;
    assign in_score = s_tdata[IN_SCORE_W-1:0];
    assign in_name  = s_tdata[IN_SCORE_W +: NAME_W];
    assign in_idx   = s_tdata[IN_SCORE_W + NAME_W +: READ_IDX_W];

    assign clamp_score = in_score[IN_SCORE_W-1] ? '0 : in_score[SCORE_W-1:0];
    assign norm_name   = normalize_name(in_name);

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;

    // Cell chain
    assign chain[0] = inject_reg;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        tkst_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (IDX_W'(i)),
            .held_count  (held_count_reg),
            .carry_in    (chain[i]),
            .carry_out   (chain[i+1]),
            .entry_score (cell_score[i]),
            .entry_name  (cell_name[i]),
            .took_new    (took_vec[i])
        );
    end

    // Locate the cell that took the new item this cycle
    always_comb begin
        took_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (took_vec[i]) begin
                took_rank = took_rank | RANK_W'(i);
            end
        end
    end
    assign any_took = |took_vec;

    // Read port
    assign rd_addr  = IDX_W'(in_idx);
    assign rd_valid = (COUNT_W'(in_idx) < held_count_reg) &&
                      (COUNT_W'(in_idx) < COUNT_W'(MAX_ENTRIES));

    // Control, result staging and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            inject_reg.valid <= 1'b0;
            held_count_reg   <= '0;
            wave_cnt_reg     <= '0;
            acc_reg          <= 1'b0;
        end else begin
            inject_reg.valid <= s_fire && (in_mode == MODE_SUBMIT);
            if ((state_reg == ST_DONE) && slot_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (in_mode == MODE_SUBMIT) begin
                            inject_reg.is_new <= 1'b1;
                            inject_reg.score  <= clamp_score;
                            inject_reg.name   <= norm_name;
                            wave_cnt_reg      <= '0;
                            acc_reg           <= 1'b0;
                            rank_reg          <= '0;
                            state_reg         <= ST_WAVE;
                        end else begin
                            pend_acc_reg   <= 1'b0;
                            pend_rank_reg  <= '0;
                            pend_ev_reg    <= rd_valid;
                            pend_score_reg <= rd_valid ? cell_score[rd_addr] : '0;
                            pend_name_reg  <= rd_valid ? cell_name[rd_addr] : '0;
                            pend_count_reg <= held_count_reg;
                            state_reg      <= ST_DONE;
                        end
                    end
                end
                ST_WAVE: begin
                    if (any_took) begin
                        acc_reg  <= 1'b1;
                        rank_reg <= took_rank;
                    end
                    wave_cnt_reg <= wave_cnt_reg + 1'b1;
                    if (wave_cnt_reg == IDX_W'(MAX_ENTRIES - 1)) begin
                        pend_acc_reg   <= acc_reg || any_took;
                        pend_rank_reg  <= any_took ? took_rank : rank_reg;
                        pend_ev_reg    <= 1'b0;
                        pend_score_reg <= '0;
                        pend_name_reg  <= '0;
                        if (held_count_reg < COUNT_W'(MAX_ENTRIES)) begin
                            held_count_reg <= held_count_reg + 1'b1;
                            pend_count_reg <= held_count_reg + 1'b1;
                        end else begin
                            pend_count_reg <= held_count_reg;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (slot_free) begin
                        m_tdata_reg  <= OUT_TDATA_W'({pend_count_reg, pend_name_reg,
                                                      pend_score_reg, pend_ev_reg,
                                                      pend_rank_reg, pend_acc_reg});
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // The table never holds more than its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= COUNT_W'(MAX_ENTRIES))
        else $error("held count beyond capacity");

    // The new item settles in at most one cell
    a_one_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(took_vec))
        else $error("new item taken by several cells");

    // Cells only take the new item while a wave runs
    a_take_in_wave: assert property (@(posedge aclk) disable iff (!aresetn)
        any_took |-> (state_reg == ST_WAVE))
        else $error("new item taken outside a wave");

    // A result never reports both an insert and a read hit
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1 + RANK_W]))
        else $error("result marks both accepted and entry_valid");
`endif

endmodule

`default_nettype wire

@@ design/tkst_cell.sv @@
`default_nettype none

module tkst_cell
    import tkst_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [IDX_W-1:0]     cell_idx,
    input  wire logic [COUNT_W-1:0]   held_count,
    input  wire carry_t               carry_in,
    output carry_t                    carry_out,
    output logic [SCORE_W-1:0]        entry_score,
    output logic [NAME_W-1:0]         entry_name,
    output logic                      took_new
);

    logic [SCORE_W-1:0] score_reg;
    logic [NAME_W-1:0]  name_reg;
    carry_t             carry_reg;
    carry_t             carry_next;
    logic               occupied;
    logic               take;

    // Claim the slot when empty, when a displaced entry shifts down, or when the
    // new item scores strictly higher
    assign occupied = COUNT_W'(cell_idx) < held_count;
    assign take     = carry_in.valid &&
                      (!occupied || !carry_in.is_new || (carry_in.score > score_reg));
    assign took_new = take && carry_in.is_new;

    // Pass on the displaced entry, or the item itself when not taken
    always_comb begin
        if (take) begin
            carry_next.valid  = occupied;
            carry_next.is_new = 1'b0;
            carry_next.score  = score_reg;
            carry_next.name   = name_reg;
        end else begin
            carry_next = carry_in;
        end
    end

    // Hold the entry
    always_ff @(posedge aclk) begin
        if (take) begin
            score_reg <= carry_in.score;
            name_reg  <= carry_in.name;
        end
    end

    // Advance the carry to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg.valid <= 1'b0;
        end else begin
            carry_reg.valid <= carry_next.valid;
        end
        carry_reg.is_new <= carry_next.is_new;
        carry_reg.score  <= carry_next.score;
        carry_reg.name   <= carry_next.name;
    end

    assign carry_out   = carry_reg;
    assign entry_score = score_reg;
    assign entry_name  = name_reg;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
module tb_top;
    import tkst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One result item as unpacked from m_tdata
    typedef struct packed {
        logic               accepted;
        logic [RANK_W-1:0]  final_rank;
        logic               entry_valid;
        logic [SCORE_W-1:0] entry_score;
        logic [NAME_W-1:0]  entry_name;
        logic [COUNT_W-1:0] entry_count;
    } standing_t;

    // One row of the directed plan; reps repeats the same item
    typedef struct packed {
        logic               mode;
        logic [31:0]        score;
        logic [NAME_W-1:0]  name;
        logic [3:0]         idx;
        logic [4:0]         reps;
        logic               typed;
        standing_t          want;
    } plan_row_t;

    localparam int PLAN_ROWS   = 15;
    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_WAIT  = 40;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the score table
    logic [SCORE_W-1:0] kept_score [MAX_ENTRIES];
    logic [NAME_W-1:0]  kept_name  [MAX_ENTRIES];
    int                 kept_count;

    standing_t due_standings[$];
    int        fault_count;
    logic      quiet_sender;
    plan_row_t plan [PLAN_ROWS];

    top_k_sorted_insert_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic standing_t mk_result(logic acc, logic [RANK_W-1:0] rank, logic ok,
                                            logic [SCORE_W-1:0] sc, logic [NAME_W-1:0] nm,
                                            logic [COUNT_W-1:0] cnt);
        standing_t r;
        r.accepted    = acc;
        r.final_rank  = rank;
        r.entry_valid = ok;
        r.entry_score = sc;
        r.entry_name  = nm;
        r.entry_count = cnt;
        return r;
    endfunction

    // Cut the name at its first zero byte; an empty name becomes the default text
    function automatic logic [NAME_W-1:0] clean_name(logic [NAME_W-1:0] tag);
        logic [NAME_W-1:0] nm;
        logic              ended;
        nm    = '0;
        ended = 1'b0;
        for (int b = 0; b < NAME_CHARS; b++) begin
            if (tag[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                nm[8*b +: 8] = tag[8*b +: 8];
        end
        if (nm == '0) begin
            for (int b = 0; b < NAME_CHARS; b++)
                nm[8*b +: 8] = DEFAULT_NAME[8*b +: 8];
        end
        return nm;
    endfunction

    // Apply one item to the shadow table and return the standing it should produce
    function automatic standing_t table_step(logic mode, logic [31:0] raw,
                                             logic [NAME_W-1:0] tag, logic [3:0] idx);
        standing_t          r;
        logic [SCORE_W-1:0] sc;
        logic [NAME_W-1:0]  nm;
        int                 pos;
        logic               take;
        r    = '0;
        take = 1'b1;
        if (mode == MODE_SUBMIT) begin
            sc = raw[31] ? '0 : raw[SCORE_W-1:0];
            nm = clean_name(tag);
            if (kept_count < MAX_ENTRIES) begin
                pos = kept_count;
                kept_count++;
            end else begin
                pos  = MAX_ENTRIES - 1;
                take = (sc > kept_score[pos]);
            end
            if (take) begin
                // bubble past strictly lower scores only, so ties keep the older entry first
                while (pos > 0 && kept_score[pos-1] < sc) begin
                    kept_score[pos] = kept_score[pos-1];
                    kept_name[pos]  = kept_name[pos-1];
                    pos--;
                end
                kept_score[pos] = sc;
                kept_name[pos]  = nm;
                r.accepted      = 1'b1;
                r.final_rank    = pos[RANK_W-1:0];
            end
        end else if (int'(idx) < kept_count) begin
            r.entry_valid = 1'b1;
            r.entry_score = kept_score[idx];
            r.entry_name  = kept_name[idx];
        end
        r.entry_count = kept_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_sender || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one item from a falling edge and hold it until it is accepted
    task automatic send_item(logic mode, logic [31:0] sc, logic [NAME_W-1:0] nm,
                             logic [3:0] idx, logic typed, standing_t want);
        int                    gap;
        logic [IN_TDATA_W-1:0] word;
        standing_t             got;
        gap  = pick_gap();
        word = '0;
        word[IN_SCORE_W-1:0]                         = sc;
        word[IN_SCORE_W +: NAME_W]                   = nm;
        word[IN_SCORE_W+NAME_W +: READ_IDX_W]        = idx;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        got = table_step(mode, sc, nm, idx);
        due_standings.push_back(typed ? want : got);
        @(negedge aclk);
    endtask

    // Drop the input and wait until every expected result has come
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (due_standings.size() != 0);
    endtask

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fault_count++;
        end
    endfunction

    // Compare each accepted result item with the oldest expectation
    always @(posedge aclk) begin
        standing_t want;
        standing_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.accepted    = m_tdata[0];
            got.final_rank  = m_tdata[1 +: RANK_W];
            got.entry_valid = m_tdata[1+RANK_W];
            got.entry_score = m_tdata[2+RANK_W +: SCORE_W];
            got.entry_name  = m_tdata[2+RANK_W+SCORE_W +: NAME_W];
            got.entry_count = m_tdata[2+RANK_W+SCORE_W+NAME_W +: COUNT_W];
            if (due_standings.size() == 0) begin
                $display("%0t: unexpected result item, actual %0h", $time, m_tdata);
                fault_count++;
            end else begin
                want = due_standings.pop_front();
                check_field("accepted",    64'(want.accepted),    64'(got.accepted));
                check_field("final_rank",  64'(want.final_rank),  64'(got.final_rank));
                check_field("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
                check_field("entry_score", 64'(want.entry_score), 64'(got.entry_score));
                check_field("entry_name",  want.entry_name,       got.entry_name);
                check_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
            end
        end
    end

    // Result side: alternate steady stretches with random and long stalls
    initial begin
        int  seg;
        logic steady;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            seg    = $urandom_range(20, 80);
            steady = ($urandom_range(0, 3) == 0);
            repeat (seg) begin
                @(negedge aclk);
                if (steady) begin
                    m_tready <= 1'b1;
                end else if ($urandom_range(0, 99) < 4) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(8, 40)) @(negedge aclk);
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= ($urandom_range(0, 99) < 70);
                end
            end
        end
    end

    initial begin
        logic                mode;
        logic [31:0]         sc;
        logic [NAME_W-1:0]   nm;
        longint              near;
        int                  pick;
        int                  k;

        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = MODE_SUBMIT;
        aresetn      = 1'b0;
        fault_count  = 0;
        kept_count   = 0;
        quiet_sender = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            kept_score[i] = '0;
            kept_name[i]  = '0;
        end

        // Directed plan: empty reads, extremes, name cleanup, ties, full-table cases
        plan[0]  = '{MODE_READ,   32'h0, 64'h0, 4'd0,  5'd1, 1'b1,
                     mk_result(1'b0, 4'd0, 1'b0, 31'd0, 64'd0, 5'd0)};
        plan[1]  = '{MODE_READ,   32'h0, 64'h0, 4'd15, 5'd1, 1'b1,
                     mk_result(1'b0, 4'd0, 1'b0, 31'd0, 64'd0, 5'd0)};
        plan[2]  = '{MODE_SUBMIT, 32'h8000_0000, 64'h0, 4'd0, 5'd1, 1'b1,
                     mk_result(1'b1, 4'd0, 1'b0, 31'd0, 64'd0, 5'd1)};
        plan[3]  = '{MODE_READ,   32'h0, 64'h0, 4'd0,  5'd1, 1'b1,
                     mk_result(1'b0, 4'd0, 1'b1, 31'd0, DEFAULT_NAME, 5'd1)};
        plan[4]  = '{MODE_SUBMIT, 32'h7FFF_FFFF, {NAME_W{1'b1}}, 4'd0, 5'd1, 1'b1,
                     mk_result(1'b1, 4'd0, 1'b0, 31'd0, 64'd0, 5'd2)};
        plan[5]  = '{MODE_READ,   32'h0, 64'h0, 4'd0,  5'd1, 1'b1,
                     mk_result(1'b0, 4'd0, 1'b1, 31'h7FFF_FFFF, {NAME_W{1'b1}}, 5'd2)};
        plan[6]  = '{MODE_SUBMIT, 32'hFFFF_FFFF, 64'h00FF_0000_FF00_0041, 4'd0, 5'd1, 1'b0,
                     standing_t'('0)};
        plan[7]  = '{MODE_SUBMIT, 32'd5, 64'h4142_4344_4546_4700, 4'd0, 5'd1, 1'b0,
                     standing_t'('0)};
        plan[8]  = '{MODE_SUBMIT, 32'd5, 64'h42, 4'd0, 5'd1, 1'b0, standing_t'('0)};
        plan[9]  = '{MODE_READ,   32'h0, 64'h0, 4'd2,  5'd1, 1'b0, standing_t'('0)};
        plan[10] = '{MODE_SUBMIT, 32'd100, 64'h46, 4'd0, 5'd11, 1'b0, standing_t'('0)};
        plan[11] = '{MODE_SUBMIT, 32'd0, 64'h5A, 4'd0, 5'd1, 1'b1,
                     mk_result(1'b0, 4'd0, 1'b0, 31'd0, 64'd0, 5'd16)};
        plan[12] = '{MODE_SUBMIT, 32'd1, 64'h31, 4'd0, 5'd1, 1'b0, standing_t'('0)};
        plan[13] = '{MODE_READ,   32'h0, 64'h0, 4'd15, 5'd1, 1'b0, standing_t'('0)};
        plan[14] = '{MODE_SUBMIT, 32'h7FFF_FFFF, 64'h54, 4'd0, 5'd1, 1'b0, standing_t'('0)};

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed plan
        for (int r = 0; r < PLAN_ROWS; r++) begin
            repeat (plan[r].reps)
                send_item(plan[r].mode, plan[r].score, plan[r].name, plan[r].idx,
                          plan[r].typed, plan[r].want);
        end

        // Hold off until every directed result is back
        wait_drain();

        // Random items; three of ten score picks land near the bottom of the full table
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet_sender = (i >= 100 && i < 150);
            if (i == RANDOM_ITEMS / 2)
                wait_drain();
            mode = ($urandom_range(0, 99) < 35) ? MODE_READ : MODE_SUBMIT;
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    sc = $urandom;
                end
                1: begin
                    sc = 32'h8000_0000 | $urandom;
                end
                2: begin
                    sc = $urandom_range(0, 20);
                end
                3, 4, 5: begin
                    near = (kept_count == MAX_ENTRIES) ? longint'(kept_score[MAX_ENTRIES-1]) : 0;
                    near = near + $urandom_range(0, 2) - 1;
                    if (near < 0)
                        near = 0;
                    if (near > 64'h7FFF_FFFF)
                        near = 64'h7FFF_FFFF;
                    sc = near[31:0];
                end
                6: begin
                    sc = (kept_count > 0) ?
                         {1'b0, kept_score[$urandom_range(0, kept_count - 1)]} : 32'd0;
                end
                7: begin
                    sc = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'd0;
                end
                default: begin
                    sc = {1'b0, 31'($urandom)};
                end
            endcase
            nm = {$urandom, $urandom};
            case ($urandom_range(0, 7))
                0: nm = '0;
                1: begin
                    k  = $urandom_range(0, NAME_CHARS - 1);
                    nm[8*k +: 8] = 8'h00;
                end
                2: nm[7:0] = 8'h00;
                default: ;
            endcase
            send_item(mode, sc, nm, 4'($urandom_range(0, 15)), 1'b0, standing_t'('0));
        end
        quiet_sender = 1'b0;

        // Let the last results arrive, then settle
        wait_drain();
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (fault_count == 0 && due_standings.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
design/tkst_pkg.sv
design/tkst_cell.sv
design/top_k_sorted_insert_table.sv
dv/tb_top.sv
